// ----- hw/rtl/npc_pkg.sv -----
// Shared types and constants for the nearest-prototype classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package npc_pkg;

    localparam int NUM_FEAT         = 8;
    localparam int FIELD_W          = 16;
    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int FEATURE_BITS_DEF = 16;
    localparam int IDX_W            = 6;
    localparam int DIST_W           = 35;
    localparam int S_TDATA_W        = NUM_FEAT * FIELD_W;
    localparam int M_TDATA_W        = ((IDX_W + DIST_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic {
        CMD_APPEND   = 1'b0,
        CMD_CLASSIFY = 1'b1
    } npc_cmd_t;

    typedef struct packed {
        logic     valid;
        npc_cmd_t cmd;
    } npc_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } npc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/npc_front.sv -----
// Front end: accepts input transfers, narrows or zero-extends features, and queues decoded items.
// Depends on npc_pkg.
`default_nettype none

module npc_front #(
    parameter int FEATURE_BITS = npc_pkg::FEATURE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [npc_pkg::S_TDATA_W-1:0]          s_axis_tdata,
    input  wire logic [0:0]                             s_axis_tuser,
    output npc_pkg::npc_ctrl_t                          q_ctrl,
    output logic [npc_pkg::NUM_FEAT*FEATURE_BITS-1:0]   q_feat,
    input  wire logic                                   q_pop
);

    localparam int FW = npc_pkg::NUM_FEAT * FEATURE_BITS;

    logic [FW-1:0]      feat;
    logic [FW-1:0]      feat_reg [2];
    npc_pkg::npc_cmd_t  cmd_reg  [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         fill_reg, fill_next;
    logic               push;

    for (genvar k = 0; k < npc_pkg::NUM_FEAT; k++) begin : g_feat
        if (FEATURE_BITS <= npc_pkg::FIELD_W) begin : g_narrow
            assign feat[k*FEATURE_BITS +: FEATURE_BITS] =
                s_axis_tdata[k*npc_pkg::FIELD_W +: FEATURE_BITS];
        end else begin : g_wide
            assign feat[k*FEATURE_BITS +: FEATURE_BITS] =
                {{(FEATURE_BITS - npc_pkg::FIELD_W){1'b0}},
                 s_axis_tdata[k*npc_pkg::FIELD_W +: npc_pkg::FIELD_W]};
        end
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    assign q_ctrl.valid = (fill_reg != 2'd0);
    assign q_ctrl.cmd   = cmd_reg[rd_ptr_reg];
    assign q_feat       = feat_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            feat_reg[wr_ptr_reg] <= feat;
            cmd_reg[wr_ptr_reg]  <= npc_pkg::npc_cmd_t'(s_axis_tuser[0]);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/npc_dist.sv -----
// Five-stage squared-distance pipeline over eight feature lanes.
// Depends on npc_pkg.
`default_nettype none

module npc_dist #(
    parameter int FEATURE_BITS = npc_pkg::FEATURE_BITS_DEF,
    parameter int IW           = 6
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_valid,
    input  wire logic [IW-1:0]                          in_idx,
    input  wire logic [npc_pkg::NUM_FEAT*FEATURE_BITS-1:0] proto,
    input  wire logic [npc_pkg::NUM_FEAT*FEATURE_BITS-1:0] query,
    output logic                                        out_valid,
    output logic [IW-1:0]                               out_idx,
    output logic [npc_pkg::DIST_W-1:0]                  out_dist,
    output logic                                        busy
);

    localparam int NF  = npc_pkg::NUM_FEAT;
    localparam int DW  = npc_pkg::DIST_W;
    localparam int AW1 = FEATURE_BITS + 1;
    localparam int SQW = 2 * AW1;
    localparam int EW  = (SQW > DW) ? SQW : DW;

    logic [AW1-1:0]  absd_reg [NF];
    logic [DW-1:0]   term_reg [NF];
    logic [DW:0]     pair_reg [NF/2];
    logic [DW+1:0]   quad_reg [NF/4];
    logic [DW-1:0]   total_reg;
    logic [DW+2:0]   total;
    logic [4:0]      valid_reg;
    logic [IW-1:0]   idx_reg [5];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NF; k++) begin
            logic signed [AW1-1:0] d;
            d = $signed({proto[k*FEATURE_BITS + FEATURE_BITS - 1],
                         proto[k*FEATURE_BITS +: FEATURE_BITS]})
              - $signed({query[k*FEATURE_BITS + FEATURE_BITS - 1],
                         query[k*FEATURE_BITS +: FEATURE_BITS]});
            absd_reg[k] <= d[AW1-1] ? AW1'(-d) : AW1'(d);
        end
        for (int k = 0; k < NF; k++) begin
            logic [SQW-1:0] sq;
            logic [EW-1:0]  sq_ext;
            sq     = absd_reg[k] * absd_reg[k];
            sq_ext = EW'(sq);
            term_reg[k] <= (sq_ext > EW'(npc_pkg::DIST_MAX)) ? npc_pkg::DIST_MAX
                                                              : sq_ext[DW-1:0];
        end
        for (int k = 0; k < NF/2; k++) begin
            pair_reg[k] <= {1'b0, term_reg[2*k]} + {1'b0, term_reg[2*k+1]};
        end
        for (int k = 0; k < NF/4; k++) begin
            quad_reg[k] <= {1'b0, pair_reg[2*k]} + {1'b0, pair_reg[2*k+1]};
        end
        total_reg <= (total > (DW+3)'(npc_pkg::DIST_MAX)) ? npc_pkg::DIST_MAX
                                                          : total[DW-1:0];
        idx_reg[0] <= in_idx;
        for (int s = 1; s < 5; s++) begin
            idx_reg[s] <= idx_reg[s-1];
        end
    end

    assign total = {1'b0, quad_reg[0]} + {1'b0, quad_reg[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    assign out_valid = valid_reg[4];
    assign out_idx   = idx_reg[4];
    assign out_dist  = total_reg;
    assign busy      = |valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/npc_engine.sv -----
// Back end: prototype memory, scan sequencer, running minimum and result register.
// Depends on npc_pkg and npc_dist.
`default_nettype none

module npc_engine #(
    parameter int MAX_ENTRIES  = npc_pkg::MAX_ENTRIES_DEF,
    parameter int FEATURE_BITS = npc_pkg::FEATURE_BITS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire npc_pkg::npc_ctrl_t                        q_ctrl,
    input  wire logic [npc_pkg::NUM_FEAT*FEATURE_BITS-1:0] q_feat,
    output logic                                           q_pop,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic                                           m_found,
    output logic [npc_pkg::IDX_W-1:0]                      m_idx,
    output logic [npc_pkg::DIST_W-1:0]                     m_dist
);

    localparam int FW = npc_pkg::NUM_FEAT * FEATURE_BITS;
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = npc_pkg::DIST_W;

    logic [FW-1:0]         mem [MAX_ENTRIES];
    logic [FW-1:0]         rd_data_reg;
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [FW-1:0]         query_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         addr_reg, addr_next;
    npc_pkg::npc_state_t   state_reg, state_next;
    logic                  best_found_reg, best_found_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [DW-1:0]         best_dist_reg, best_dist_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  do_append, do_write, do_load, last_addr;
    logic                  d_valid, d_busy;
    logic [AW-1:0]         d_idx;
    logic [DW-1:0]         d_dist;

    assign q_pop     = (state_reg == npc_pkg::ST_IDLE) && q_ctrl.valid;
    assign do_append = q_pop && (q_ctrl.cmd == npc_pkg::CMD_APPEND);
    assign do_write  = do_append && (count_reg < CW'(MAX_ENTRIES));
    assign last_addr = (CW'(addr_reg) + CW'(1)) == count_reg;
    assign do_load   = (state_reg == npc_pkg::ST_DRAIN) && !rd_valid_reg && !d_busy
                       && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        unique case (state_reg)
            npc_pkg::ST_IDLE: begin
                if (do_write) begin
                    count_next = count_reg + CW'(1);
                end
                if (q_pop && !do_append) begin
                    addr_next       = '0;
                    best_found_next = 1'b0;
                    best_idx_next   = '0;
                    best_dist_next  = '0;
                    state_next      = (count_reg == '0) ? npc_pkg::ST_DRAIN
                                                        : npc_pkg::ST_SCAN;
                end
            end
            npc_pkg::ST_SCAN: begin
                if (last_addr) begin
                    state_next = npc_pkg::ST_DRAIN;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            npc_pkg::ST_DRAIN: begin
                if (do_load) begin
                    m_valid_next = 1'b1;
                    state_next   = npc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npc_pkg::ST_IDLE;
            end
        endcase
        if (d_valid && (!best_found_reg || d_dist < best_dist_reg)) begin
            best_found_next = 1'b1;
            best_idx_next   = d_idx;
            best_dist_next  = d_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= npc_pkg::ST_IDLE;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= (state_reg == npc_pkg::ST_SCAN);
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        rd_idx_reg     <= addr_reg;
        if (q_pop) begin
            query_reg <= q_feat;
        end
        if (do_load) begin
            m_found <= best_found_reg;
            m_idx   <= npc_pkg::IDX_W'(best_idx_reg);
            m_dist  <= best_dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[count_reg[AW-1:0]] <= q_feat;
        end
        rd_data_reg <= mem[addr_reg];
    end

    npc_dist #(
        .FEATURE_BITS (FEATURE_BITS),
        .IW           (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_idx    (rd_idx_reg),
        .proto     (rd_data_reg),
        .query     (query_reg),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_dist  (d_dist),
        .busy      (d_busy)
    );

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_prototype_classifier.sv -----
// Nearest-prototype classifier, top level: front queue, scan engine, result port.
// Depends on npc_pkg, npc_front, npc_engine and npc_dist.
// Append: leaves the two-entry queue once it is at the head and the engine is idle; no result.
// Classify: one prototype per cycle through a five-stage distance pipeline; result loads
// once it has drained and no unaccepted result is held (no scan for an empty table);
// one classify at a time. aresetn (synchronous, active low) empties queue, count.
`default_nettype none

module nearest_prototype_classifier #(
    parameter int MAX_ENTRIES  = npc_pkg::MAX_ENTRIES_DEF,
    parameter int FEATURE_BITS = npc_pkg::FEATURE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // mouth_width, mouth_height, brow_left, brow_right, eye_left, eye_right,
    // jaw_open, nostril_flare
    input  wire logic [npc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // cmd
    input  wire logic [0:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // best_index, best_distance_sq, zero padding
    output logic [npc_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    // found
    output logic [0:0]                              m_axis_tuser
);

    localparam int FW = npc_pkg::NUM_FEAT * FEATURE_BITS;

    npc_pkg::npc_ctrl_t             q_ctrl;
    logic [FW-1:0]                  q_feat;
    logic                           q_pop;
    logic                           m_found;
    logic [npc_pkg::IDX_W-1:0]      m_idx;
    logic [npc_pkg::DIST_W-1:0]     m_dist;

    npc_front #(
        .FEATURE_BITS (FEATURE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_ctrl        (q_ctrl),
        .q_feat        (q_feat),
        .q_pop         (q_pop)
    );

    npc_engine #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_ctrl  (q_ctrl),
        .q_feat  (q_feat),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_found (m_found),
        .m_idx   (m_idx),
        .m_dist  (m_dist)
    );

    assign m_axis_tuser = m_found;
    assign m_axis_tdata = {{(npc_pkg::M_TDATA_W - npc_pkg::IDX_W - npc_pkg::DIST_W){1'b0}},
                           m_dist, m_idx};

`ifndef ASSERT_OFF
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_ctrl.valid)
        else $error("queue popped while empty");

    a_classify_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_ctrl.cmd == npc_pkg::CMD_CLASSIFY) |=> !q_pop)
        else $error("engine popped again during a classify");

    a_empty_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("empty-table result carries non-zero data");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for nearest_prototype_classifier: appends and classifies
// prototypes over the stream ports and checks every match against its own predictor.
// Depends on npc_pkg and the nearest_prototype_classifier RTL.

module tb_top;

    localparam int RANDOM_ITEMS   = 685;
    localparam int TAIL_ITEMS     = 100;
    localparam int HOLD_AT        = 120;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = npc_pkg::MAX_ENTRIES_DEF + 16;

    typedef logic signed [npc_pkg::FIELD_W-1:0] feat_t;
    typedef feat_t feat_vec_t [npc_pkg::NUM_FEAT];

    typedef struct {
        logic                       found;
        logic [npc_pkg::IDX_W-1:0]  best_index;
        logic [npc_pkg::DIST_W-1:0] best_distance_sq;
    } match_t;

    class match_board;
        feat_vec_t   proto_mem [npc_pkg::MAX_ENTRIES_DEF];
        int unsigned entry_count = 0;
        match_t      expected_matches [$];
        int unsigned mismatches = 0;

        function void take_item(npc_pkg::npc_cmd_t cmd,
                                logic [npc_pkg::S_TDATA_W-1:0] data);
            feat_vec_t                        v;
            match_t                           m;
            logic [npc_pkg::DIST_W-1:0]       sum;
            logic [npc_pkg::DIST_W-1:0]       sq;
            logic signed [npc_pkg::FIELD_W:0] diff;
            logic [npc_pkg::FIELD_W:0]        mag;
            for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
                v[k] = data[k*npc_pkg::FIELD_W +: npc_pkg::FIELD_W];
            end
            if (cmd == npc_pkg::CMD_APPEND) begin
                if (entry_count < npc_pkg::MAX_ENTRIES_DEF) begin
                    proto_mem[entry_count] = v;
                    entry_count++;
                end
                return;
            end
            m.found            = 1'b0;
            m.best_index       = '0;
            m.best_distance_sq = '0;
            for (int i = 0; i < entry_count; i++) begin
                sum = '0;
                for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
                    diff = proto_mem[i][k] - v[k];
                    mag  = diff[npc_pkg::FIELD_W] ? -diff : diff;
                    sq   = mag * mag;
                    sum  = sum + sq;
                end
                if (!m.found || sum < m.best_distance_sq) begin
                    m.found            = 1'b1;
                    m.best_index       = i[npc_pkg::IDX_W-1:0];
                    m.best_distance_sq = sum;
                end
            end
            expected_matches.insert(expected_matches.size(), m);
        endfunction

        function void check_match(logic [npc_pkg::M_TDATA_W-1:0] data, logic found);
            match_t m;
            if (expected_matches.size() == 0) begin
                $error("result transfer with no classify outstanding");
                mismatches++;
                return;
            end
            m = expected_matches.pop_front();
            if (found !== m.found) begin
                $error("found: expected %0d, got %0d", m.found, found);
                mismatches++;
            end
            if (data[npc_pkg::IDX_W-1:0] !== m.best_index) begin
                $error("best_index: expected %0d, got %0d", m.best_index,
                       data[npc_pkg::IDX_W-1:0]);
                mismatches++;
            end
            if (data[npc_pkg::IDX_W +: npc_pkg::DIST_W] !== m.best_distance_sq) begin
                $error("best_distance_sq: expected %0d, got %0d",
                       m.best_distance_sq, data[npc_pkg::IDX_W +: npc_pkg::DIST_W]);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [npc_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [npc_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]                      m_axis_tuser;

    match_board  board = new();
    feat_vec_t   stored_protos [$];
    int          items_offered = 0;
    bit          calm_tail = 1'b0;
    bit          tx_calm = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    nearest_prototype_classifier i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.take_item(npc_pkg::npc_cmd_t'(s_axis_tuser[0]), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_match(m_axis_tdata, m_axis_tuser[0]);
            end
        end
    end

    function automatic feat_vec_t uniform(input feat_t x);
        feat_vec_t v;
        for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
            v[k] = x;
        end
        return v;
    endfunction

    function automatic feat_t rand_feature();
        case ($urandom_range(0, 9))
            0:       return feat_t'(-32768);
            1:       return feat_t'(32767);
            2:       return feat_t'(0);
            3:       return feat_t'(-1);
            default: return feat_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic feat_vec_t rand_vector();
        feat_vec_t v;
        for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
            v[k] = rand_feature();
        end
        return v;
    endfunction

    function automatic feat_vec_t near_vector(input feat_vec_t base);
        feat_vec_t v;
        for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
            v[k] = base[k] + feat_t'(int'($urandom_range(0, 64)) - 32);
        end
        return v;
    endfunction

    task automatic offer(input npc_pkg::npc_cmd_t cmd, input feat_vec_t v);
        logic [npc_pkg::S_TDATA_W-1:0] data;
        for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
            data[k*npc_pkg::FIELD_W +: npc_pkg::FIELD_W] = v[k];
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        items_offered++;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Record stored prototypes for stimulus, then transfer and maybe idle.
    task automatic send(input npc_pkg::npc_cmd_t cmd, input feat_vec_t v);
        if (items_offered % 40 == 0) begin
            tx_calm = ($urandom_range(0, 2) == 0);
        end
        if (cmd == npc_pkg::CMD_APPEND && stored_protos.size() < npc_pkg::MAX_ENTRIES_DEF) begin
            stored_protos.insert(stored_protos.size(), v);
        end
        offer(cmd, v);
        if (!calm_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    initial begin : result_sink
        int unsigned cycle;
        int          stall_left;
        int          hold_left;
        bit          held_off;
        bit          rx_calm;
        cycle      = 0;
        stall_left = 0;
        hold_left  = 0;
        held_off   = 1'b0;
        rx_calm    = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (cycle % 256 == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            // hold off once for long enough that the block backs up its input
            if (!held_off && items_offered >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        feat_vec_t          v;
        npc_pkg::npc_cmd_t  cmd;
        int                 n_real;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= npc_pkg::CMD_APPEND;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(0)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(32767)));
        // extremes and largest distance
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(-32768)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(32767)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(-32768)));
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(32767)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(0)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(-1)));
        // ties: duplicate prototypes, then two equidistant ones
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(0)));
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(0)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(0)));
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(100)));
        send(npc_pkg::CMD_APPEND, uniform(feat_t'(300)));
        send(npc_pkg::CMD_CLASSIFY, uniform(feat_t'(200)));
        for (int k = 0; k < npc_pkg::NUM_FEAT; k++) begin
            v[k] = k[0] ? feat_t'(-32768) : feat_t'(32767);
        end
        send(npc_pkg::CMD_APPEND, v);
        send(npc_pkg::CMD_CLASSIFY, v);
        send(npc_pkg::CMD_CLASSIFY, rand_vector());

        n_real = 0;
        while (n_real < RANDOM_ITEMS) begin
            calm_tail = (n_real >= RANDOM_ITEMS - TAIL_ITEMS);
            if ($urandom_range(0, 6) == 0) begin
                cmd = npc_pkg::CMD_APPEND;
                if (stored_protos.size() > 0 && $urandom_range(0, 4) == 0) begin
                    v = stored_protos[$urandom_range(0, stored_protos.size() - 1)];
                end else begin
                    v = rand_vector();
                end
                // appends to a full table are dropped and do not count
                if (stored_protos.size() < npc_pkg::MAX_ENTRIES_DEF) begin
                    n_real++;
                end
            end else begin
                cmd = npc_pkg::CMD_CLASSIFY;
                case ($urandom_range(0, 5))
                    0: v = stored_protos[$urandom_range(0, stored_protos.size() - 1)];
                    1, 2: v = near_vector(stored_protos[$urandom_range(0,
                                                                        stored_protos.size() - 1)]);
                    default: v = rand_vector();
                endcase
                n_real++;
            end
            send(cmd, v);
        end
        s_axis_tvalid <= 1'b0;

        do @(negedge aclk); while (board.expected_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/npc_pkg.sv
hw/rtl/npc_front.sv
hw/rtl/npc_dist.sv
hw/rtl/npc_engine.sv
hw/rtl/nearest_prototype_classifier.sv
test/tb_top.sv
